// File: hw/rtl/ultrasonic_obstacle_avoid_decider_defines.svh
// ---------------------------------------------------------------------------
// Obstacle avoid decider: assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ---------------------------------------------------------------------------
`ifndef ULTRASONIC_OBSTACLE_AVOID_DECIDER_DEFINES_SVH
`define ULTRASONIC_OBSTACLE_AVOID_DECIDER_DEFINES_SVH

// same-cycle implication
`define UOAD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UOAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/uoad_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Obstacle avoid decider package
// Command codes, register indexes, distance thresholds and shared types.
// ---------------------------------------------------------------------------
package uoad_pkg;

    // motor command codes
    localparam logic [1:0] CMD_FORWARD = 2'd0;
    localparam logic [1:0] CMD_BACK    = 2'd1;
    localparam logic [1:0] CMD_LEFT    = 2'd2;
    localparam logic [1:0] CMD_RIGHT   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_SPEED_FAST      = 3'd0;
    localparam logic [2:0] REG_SPEED_MID       = 3'd1;
    localparam logic [2:0] REG_SPEED_SLOW      = 3'd2;
    localparam logic [2:0] REG_BACK_INTERVAL   = 3'd3;
    localparam logic [2:0] REG_ACTION_INTERVAL = 3'd4;
    localparam logic [2:0] REG_TURN_INTERVAL   = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SPEED_W    = 10;
    localparam int DIST_W     = 9;
    localparam int TIME_W     = 32;

    // filter: f = (26112*x + 154*f) >> 8, alpha = 102/256
    localparam int FILT_W        = 17;
    localparam int FILT_FRAC     = 8;
    localparam int FILT_SUM_W    = 26;
    localparam int FILT_NEW_GAIN = 26112;
    localparam int FILT_OLD_GAIN = 154;

    // distance thresholds in cm
    localparam logic [8:0] REPLACE_CM     = 9'd50;
    localparam logic [8:0] ALL_BLOCK_CM   = 9'd15;
    localparam logic [8:0] FRONT_BLOCK_CM = 9'd20;
    localparam logic [8:0] SIDE_BLOCK_CM  = 9'd15;
    localparam logic [8:0] TURN_ROOM_CM   = 9'd28;
    localparam logic [8:0] FRONT_MIN_CM   = 9'd3;
    localparam logic [8:0] SIDE_CLOSE_CM  = 9'd18;
    localparam logic [8:0] FRONT_CLOSE_CM = 9'd23;
    localparam logic [8:0] FRONT_CLEAR_CM = 9'd21;
    localparam logic [8:0] SIDE_CLEAR_CM  = 9'd17;

    typedef struct packed {
        logic [9:0]  speed_fast;
        logic [9:0]  speed_mid;
        logic [9:0]  speed_slow;
        logic [15:0] back_interval_ms;
        logic [15:0] action_interval_ms;
        logic [15:0] turn_interval_ms;
    } cfg_t;

    // one decided action: a back/forward command, optionally a turn after it
    typedef struct packed {
        logic [1:0] first_cmd;
        logic       has_turn;
        logic [1:0] turn_cmd;
        logic       turn_slow_first;
    } entry_t;

endpackage

// File: hw/rtl/uoad_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Obstacle avoid decider: front end
// Filters side readings, classifies each tick against the rules, applies
// the time gates and pushes one action entry per acting tick.
// ---------------------------------------------------------------------------
`include "ultrasonic_obstacle_avoid_decider_defines.svh"

module uoad_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  uoad_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          now_ms,
    input  logic [8:0]           front_cm,
    input  logic [8:0]           left_cm,
    input  logic [8:0]           right_cm,
    output logic                 push,
    output uoad_pkg::entry_t     push_entry,
    input  logic                 q_ready
);

    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_ALL   = 3'd1;
    localparam logic [2:0] MODE_FR    = 3'd2;
    localparam logic [2:0] MODE_FL    = 3'd3;
    localparam logic [2:0] MODE_SIDE  = 3'd4;
    localparam logic [2:0] MODE_CLEAR = 3'd5;

    logic                             in_accept;
    logic [uoad_pkg::FILT_SUM_W-1:0]  left_sum;
    logic [uoad_pkg::FILT_SUM_W-1:0]  right_sum;
    logic [uoad_pkg::FILT_W-1:0]      left_filt_next;
    logic [uoad_pkg::FILT_W-1:0]      right_filt_next;
    logic [uoad_pkg::FILT_W-1:0]      left_filt_reg;
    logic [uoad_pkg::FILT_W-1:0]      right_filt_reg;
    logic [8:0]                       left_eff;
    logic [8:0]                       right_eff;

    logic                             s2_valid_reg;
    logic                             s2_valid_next;
    logic [31:0]                      s2_now_reg;
    logic [8:0]                       s2_front_reg;
    logic [8:0]                       s2_left_reg;
    logic [8:0]                       s2_right_reg;
    logic                             s2_adv;

    logic [31:0]                      last_action_reg;
    logic [31:0]                      last_turn_reg;
    logic [31:0]                      act_elapsed;
    logic [31:0]                      turn_elapsed;

    logic [2:0]                       mode;
    logic [15:0]                      gap_ms;
    logic                             act_ok;
    logic                             turn_ok;
    logic                             backing;
    logic                             emit;
    logic                             turn_found;
    logic [1:0]                       turn_cmd;
    logic                             turn_slow_first;

    // ---------------- stage 1: filter and replacement ----------------
    assign in_accept = in_valid && in_ready;
    assign in_ready  = !s2_valid_reg || s2_adv;

    assign left_sum  = uoad_pkg::FILT_SUM_W'(left_cm) *
                       uoad_pkg::FILT_SUM_W'(uoad_pkg::FILT_NEW_GAIN) +
                       uoad_pkg::FILT_SUM_W'(left_filt_reg) *
                       uoad_pkg::FILT_SUM_W'(uoad_pkg::FILT_OLD_GAIN);
    assign right_sum = uoad_pkg::FILT_SUM_W'(right_cm) *
                       uoad_pkg::FILT_SUM_W'(uoad_pkg::FILT_NEW_GAIN) +
                       uoad_pkg::FILT_SUM_W'(right_filt_reg) *
                       uoad_pkg::FILT_SUM_W'(uoad_pkg::FILT_OLD_GAIN);

    assign left_filt_next  = left_sum[uoad_pkg::FILT_FRAC +: uoad_pkg::FILT_W];
    assign right_filt_next = right_sum[uoad_pkg::FILT_FRAC +: uoad_pkg::FILT_W];

    // far side readings use the integer part of the filtered value
    assign left_eff  = (left_cm >= uoad_pkg::REPLACE_CM) ?
                       left_filt_next[uoad_pkg::FILT_W-1:uoad_pkg::FILT_FRAC] : left_cm;
    assign right_eff = (right_cm >= uoad_pkg::REPLACE_CM) ?
                       right_filt_next[uoad_pkg::FILT_W-1:uoad_pkg::FILT_FRAC] : right_cm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_filt_reg  <= '0;
            right_filt_reg <= '0;
        end
        else if (in_accept)
        begin
            left_filt_reg  <= left_filt_next;
            right_filt_reg <= right_filt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s2_now_reg   <= now_ms;
            s2_front_reg <= front_cm;
            s2_left_reg  <= left_eff;
            s2_right_reg <= right_eff;
        end
    end

    assign s2_valid_next = in_accept ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s2_valid_next;
    end

    // ---------------- stage 2: rules and gates ----------------
    assign act_elapsed  = s2_now_reg - last_action_reg;
    assign turn_elapsed = s2_now_reg - last_turn_reg;

    always_comb
    begin
        if (s2_front_reg <= uoad_pkg::ALL_BLOCK_CM && s2_left_reg <= uoad_pkg::ALL_BLOCK_CM &&
            s2_right_reg <= uoad_pkg::ALL_BLOCK_CM)
            mode = MODE_ALL;
        else if (s2_front_reg <= uoad_pkg::FRONT_BLOCK_CM &&
                 s2_right_reg <= uoad_pkg::SIDE_BLOCK_CM)
            mode = MODE_FR;
        else if (s2_front_reg <= uoad_pkg::FRONT_BLOCK_CM &&
                 s2_left_reg <= uoad_pkg::SIDE_BLOCK_CM)
            mode = MODE_FL;
        else if ((s2_front_reg >= uoad_pkg::FRONT_MIN_CM &&
                  (s2_left_reg <= uoad_pkg::SIDE_CLOSE_CM ||
                   s2_right_reg <= uoad_pkg::SIDE_CLOSE_CM)) ||
                 s2_front_reg <= uoad_pkg::FRONT_CLOSE_CM)
            mode = MODE_SIDE;
        else if (s2_front_reg >= uoad_pkg::FRONT_CLEAR_CM &&
                 s2_left_reg >= uoad_pkg::SIDE_CLEAR_CM &&
                 s2_right_reg >= uoad_pkg::SIDE_CLEAR_CM)
            mode = MODE_CLEAR;
        else
            mode = MODE_NONE;
    end

    assign gap_ms  = (mode == MODE_ALL) ? cfg.back_interval_ms : cfg.action_interval_ms;
    assign act_ok  = act_elapsed >= 32'(gap_ms);
    assign turn_ok = turn_elapsed >= 32'(cfg.turn_interval_ms);
    assign backing = (mode == MODE_ALL) || (mode == MODE_FR) ||
                     (mode == MODE_FL) || (mode == MODE_SIDE);
    assign emit    = (mode != MODE_NONE) && act_ok;

    always_comb
    begin
        turn_found      = 1'b0;
        turn_cmd        = uoad_pkg::CMD_LEFT;
        turn_slow_first = 1'b0;
        case (mode)
            MODE_ALL:
            begin
                if (s2_left_reg > s2_right_reg)
                begin
                    turn_found      = 1'b1;
                    turn_cmd        = uoad_pkg::CMD_LEFT;
                    turn_slow_first = 1'b1;
                end
                else if (s2_left_reg < s2_right_reg)
                begin
                    turn_found = 1'b1;
                    turn_cmd   = uoad_pkg::CMD_RIGHT;
                end
            end
            MODE_FR:
            begin
                // always true here since right is already within 15 cm
                if (s2_right_reg <= uoad_pkg::TURN_ROOM_CM)
                begin
                    turn_found = 1'b1;
                    turn_cmd   = uoad_pkg::CMD_LEFT;
                end
            end
            MODE_FL:
            begin
                if (s2_left_reg <= uoad_pkg::TURN_ROOM_CM)
                begin
                    turn_found      = 1'b1;
                    turn_cmd        = uoad_pkg::CMD_RIGHT;
                    turn_slow_first = 1'b1;
                end
            end
            MODE_SIDE:
            begin
                if (s2_left_reg > s2_right_reg)
                begin
                    turn_found = 1'b1;
                    turn_cmd   = uoad_pkg::CMD_LEFT;
                end
                else if (s2_left_reg < s2_right_reg)
                begin
                    turn_found      = 1'b1;
                    turn_cmd        = uoad_pkg::CMD_RIGHT;
                    turn_slow_first = 1'b1;
                end
            end
            default:
            begin
                turn_found = 1'b0;
            end
        endcase
    end

    assign push_entry.first_cmd       = backing ? uoad_pkg::CMD_BACK : uoad_pkg::CMD_FORWARD;
    assign push_entry.has_turn        = backing && turn_ok && turn_found;
    assign push_entry.turn_cmd        = turn_cmd;
    assign push_entry.turn_slow_first = turn_slow_first;

    // ticks with no action retire without touching the queue
    assign s2_adv = s2_valid_reg && (q_ready || !emit);
    assign push   = s2_valid_reg && emit && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_action_reg <= '0;
            last_turn_reg   <= '0;
        end
        else if (push)
        begin
            last_action_reg <= s2_now_reg;
            // turn stamp moves even when no turn is sent on equal sides
            if (backing && turn_ok)
                last_turn_reg <= s2_now_reg;
        end
    end

    `UOAD_ASSERT_NEXT(a_action_stamp, push, last_action_reg == $past(s2_now_reg),
        "action stamp not taken from the acting tick")
    `UOAD_ASSERT_IMPL(a_turn_needs_back, push && push_entry.has_turn,
        push_entry.first_cmd == uoad_pkg::CMD_BACK, "turn queued without a back command")

endmodule

// File: hw/rtl/uoad_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Obstacle avoid decider: action queue
// Small register FIFO between the rule front end and the command back end.
// ---------------------------------------------------------------------------
`include "ultrasonic_obstacle_avoid_decider_defines.svh"

module uoad_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  uoad_pkg::entry_t push_entry,
    output logic             ready,
    input  logic             pop,
    output logic             valid,
    output uoad_pkg::entry_t entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    uoad_pkg::entry_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign ready = count_reg != CNT_W'(DEPTH);
    assign valid = count_reg != '0;
    assign entry = slot_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    `UOAD_ASSERT_IMPL(a_no_overflow, push, ready, "push into a full queue")
    `UOAD_ASSERT_IMPL(a_no_underflow, pop, valid, "pop from an empty queue")

endmodule

// File: hw/rtl/uoad_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Obstacle avoid decider: back end
// Expands each action entry into one or two motor commands and holds them
// in the output register until the receiver takes them.
// ---------------------------------------------------------------------------
`include "ultrasonic_obstacle_avoid_decider_defines.svh"

module uoad_back (
    input  logic             clk,
    input  logic             rst_n,
    input  uoad_pkg::cfg_t   cfg,
    input  logic             q_valid,
    input  uoad_pkg::entry_t q_entry,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       command,
    output logic [9:0]       first_speed,
    output logic [9:0]       second_speed,
    output logic             last
);

    localparam logic PH_BASE = 1'b0;  // back or forward command next
    localparam logic PH_TURN = 1'b1;  // turn command next

    logic       phase_reg;
    logic       phase_next;
    logic       load;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [1:0] command_reg;
    logic [9:0] first_speed_reg;
    logic [9:0] second_speed_reg;
    logic       last_reg;

    assign load = q_valid && (!out_valid_reg || out_ready);
    assign pop  = load && ((phase_reg == PH_TURN) || !q_entry.has_turn);

    always_comb
    begin
        phase_next = phase_reg;
        if (load)
        begin
            if (phase_reg == PH_BASE && q_entry.has_turn)
                phase_next = PH_TURN;
            else
                phase_next = PH_BASE;
        end
    end

    assign out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BASE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (phase_reg == PH_BASE)
            begin
                command_reg      <= q_entry.first_cmd;
                first_speed_reg  <= cfg.speed_fast;
                second_speed_reg <= cfg.speed_fast;
                last_reg         <= !q_entry.has_turn;
            end
            else
            begin
                command_reg      <= q_entry.turn_cmd;
                first_speed_reg  <= q_entry.turn_slow_first ? cfg.speed_slow : cfg.speed_mid;
                second_speed_reg <= q_entry.turn_slow_first ? cfg.speed_mid : cfg.speed_slow;
                last_reg         <= 1'b1;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign command      = command_reg;
    assign first_speed  = first_speed_reg;
    assign second_speed = second_speed_reg;
    assign last         = last_reg;

    `UOAD_ASSERT_NEXT(a_turn_follows, load && phase_reg == PH_BASE && q_entry.has_turn,
        phase_reg == PH_TURN && out_valid_reg && !last_reg,
        "back command before a turn not marked as non-final")
    `UOAD_ASSERT_IMPL(a_turn_entry_held, phase_reg == PH_TURN, q_valid && q_entry.has_turn,
        "turn pending without its queue entry")

endmodule

// File: hw/rtl/ultrasonic_obstacle_avoid_decider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ultrasonic obstacle avoid decider, top level
// Control ticks in (time plus front/left/right distance), motor commands out.
//
// Input channel in_valid/in_ready carries one tick per transfer. Output
// channel out_valid/out_ready carries one motor command per transfer; last
// marks the final command of a tick. A tick makes zero, one or two commands.
// A tick's first command passes the rule stage, the action queue, then
// the output register. Throughput: one tick per cycle while each tick
// makes at most one command and out_ready stays high; the output register
// sends one command per cycle, so a tick with a turn holds it for both
// commands. The action queue (QUEUE_DEPTH entries) between the rule stage
// and the output lets the input keep flowing while the receiver stalls;
// when it fills, in_ready drops until commands are taken.
// Configuration writes (cfg_we/cfg_index/cfg_wdata) take effect at once.
// Reset restores the register defaults, clears both side filters and both
// time stamps and empties the pipeline and queue.
// ---------------------------------------------------------------------------

module ultrasonic_obstacle_avoid_decider #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] now_ms,
    input  logic [8:0]  front_cm,
    input  logic [8:0]  left_cm,
    input  logic [8:0]  right_cm,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  command,
    output logic [9:0]  first_speed,
    output logic [9:0]  second_speed,
    output logic        last
);

    uoad_pkg::cfg_t   cfg_reg;
    uoad_pkg::entry_t push_entry;
    uoad_pkg::entry_t q_entry;
    logic             push;
    logic             q_ready;
    logic             q_valid;
    logic             pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_fast         <= 10'd80;
            cfg_reg.speed_mid          <= 10'd70;
            cfg_reg.speed_slow         <= 10'd50;
            cfg_reg.back_interval_ms   <= 16'd300;
            cfg_reg.action_interval_ms <= 16'd100;
            cfg_reg.turn_interval_ms   <= 16'd300;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                uoad_pkg::REG_SPEED_FAST:      cfg_reg.speed_fast <= cfg_wdata[9:0];
                uoad_pkg::REG_SPEED_MID:       cfg_reg.speed_mid <= cfg_wdata[9:0];
                uoad_pkg::REG_SPEED_SLOW:      cfg_reg.speed_slow <= cfg_wdata[9:0];
                uoad_pkg::REG_BACK_INTERVAL:   cfg_reg.back_interval_ms <= cfg_wdata;
                uoad_pkg::REG_ACTION_INTERVAL: cfg_reg.action_interval_ms <= cfg_wdata;
                uoad_pkg::REG_TURN_INTERVAL:   cfg_reg.turn_interval_ms <= cfg_wdata;
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

    uoad_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .now_ms     (now_ms),
        .front_cm   (front_cm),
        .left_cm    (left_cm),
        .right_cm   (right_cm),
        .push       (push),
        .push_entry (push_entry),
        .q_ready    (q_ready)
    );

    uoad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .ready      (q_ready),
        .pop        (pop),
        .valid      (q_valid),
        .entry      (q_entry)
    );

    uoad_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .command      (command),
        .first_speed  (first_speed),
        .second_speed (second_speed),
        .last         (last)
    );

endmodule

// File: test/ultrasonic_obstacle_avoid_decider_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Obstacle avoid decider testbench
// Sends control ticks through the input channel and predicts the motor
// commands of each accepted tick with a cycle-free model of the side filters,
// priority rules and time gates. Every output transfer is checked against
// the oldest prediction. Register settings change between phases while idle.
// ---------------------------------------------------------------------------

module ultrasonic_obstacle_avoid_decider_test;

    localparam int CYCLE_LIMIT   = 800000;
    localparam int LONG_HOLD     = 150;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS   = 10;

    // indexes outside the register map, writes must be dropped
    localparam logic [2:0] REG_UNUSED_A = 3'd6;
    localparam logic [2:0] REG_UNUSED_B = 3'd7;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [8:0]  front_cm;
        logic [8:0]  left_cm;
        logic [8:0]  right_cm;
    } tick_t;

    typedef struct packed {
        logic [1:0] command;
        logic [9:0] first_speed;
        logic [9:0] second_speed;
        logic       last;
    } motor_cmd_t;

    typedef enum logic [2:0] {
        RULE_ALL_BLOCKED,
        RULE_FRONT_RIGHT,
        RULE_FRONT_LEFT,
        RULE_SIDE_GAP,
        RULE_ALL_CLEAR
    } rule_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] now_ms = '0;
    logic [8:0]  front_cm = '0;
    logic [8:0]  left_cm = '0;
    logic [8:0]  right_cm = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  command;
    logic [9:0]  first_speed;
    logic [9:0]  second_speed;
    logic        last;

    // predictor state
    uoad_pkg::cfg_t model_cfg;
    logic [16:0]    left_filt;
    logic [16:0]    right_filt;
    logic [31:0]    action_stamp;
    logic [31:0]    turn_stamp;

    tick_t       pending_ticks[$];
    motor_cmd_t  expected_cmds[$];
    tick_t       offered;
    logic [31:0] clock_ms;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // sender and receiver pacing
    int send_gap = 0;
    int send_run = 0;
    bit send_calm = 1'b0;
    int recv_stall = 0;
    int recv_run = 0;
    bit recv_calm = 1'b0;
    bit flood = 1'b0;
    int hold_requests = 0;
    int holds_done = 0;

    ultrasonic_obstacle_avoid_decider i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .now_ms       (now_ms),
        .front_cm     (front_cm),
        .left_cm      (left_cm),
        .right_cm     (right_cm),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .command      (command),
        .first_speed  (first_speed),
        .second_speed (second_speed),
        .last         (last)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic logic [16:0] filter_step(input logic [16:0] acc, input logic [8:0] cm);
        logic [31:0] sum;
        sum = 32'd26112 * {23'd0, cm} + 32'd154 * {15'd0, acc};
        return sum[24:8];
    endfunction

    function automatic bit gate_open(input logic [31:0] now, input logic [31:0] stamp,
                                     input logic [15:0] interval);
        logic [31:0] elapsed;
        elapsed = now - stamp;
        return elapsed >= {16'd0, interval};
    endfunction

    function automatic motor_cmd_t make_cmd(input logic [1:0] code, input logic [9:0] a,
                                            input logic [9:0] b);
        motor_cmd_t c;
        c.command      = code;
        c.first_speed  = a;
        c.second_speed = b;
        c.last         = 1'b0;
        return c;
    endfunction

    task automatic predict_commands(input tick_t t);
        int          f;
        int          l;
        int          r;
        int          diff;
        rule_e       rule;
        logic [15:0] gap;
        motor_cmd_t  lead;
        motor_cmd_t  turn;
        bit          has_turn;

        left_filt  = filter_step(left_filt, t.left_cm);
        right_filt = filter_step(right_filt, t.right_cm);
        f = int'(t.front_cm);
        l = (t.left_cm >= 9'd50) ? int'(left_filt >> 8) : int'(t.left_cm);
        r = (t.right_cm >= 9'd50) ? int'(right_filt >> 8) : int'(t.right_cm);
        diff = l - r;

        if (f <= 15 && l <= 15 && r <= 15)
        begin
            rule = RULE_ALL_BLOCKED;
            gap  = model_cfg.back_interval_ms;
        end
        else if (f <= 20 && r <= 15)
        begin
            rule = RULE_FRONT_RIGHT;
            gap  = model_cfg.action_interval_ms;
        end
        else if (f <= 20 && l <= 15)
        begin
            rule = RULE_FRONT_LEFT;
            gap  = model_cfg.action_interval_ms;
        end
        else if ((f >= 3 && (l <= 18 || r <= 18)) || f <= 23)
        begin
            rule = RULE_SIDE_GAP;
            gap  = model_cfg.action_interval_ms;
        end
        else if (f >= 21 && l >= 17 && r >= 17)
        begin
            rule = RULE_ALL_CLEAR;
            gap  = model_cfg.action_interval_ms;
        end
        else
        begin
            return;
        end

        // closed action gate: nothing sent, stamps kept
        if (!gate_open(t.now_ms, action_stamp, gap))
            return;

        has_turn = 1'b0;
        turn     = '0;
        if (rule == RULE_ALL_CLEAR)
        begin
            lead = make_cmd(uoad_pkg::CMD_FORWARD, model_cfg.speed_fast,
                            model_cfg.speed_fast);
        end
        else
        begin
            lead = make_cmd(uoad_pkg::CMD_BACK, model_cfg.speed_fast, model_cfg.speed_fast);
            if (gate_open(t.now_ms, turn_stamp, model_cfg.turn_interval_ms))
            begin
                case (rule)
                    RULE_ALL_BLOCKED:
                    begin
                        if (diff > 0)
                        begin
                            turn = make_cmd(uoad_pkg::CMD_LEFT, model_cfg.speed_slow,
                                            model_cfg.speed_mid);
                            has_turn = 1'b1;
                        end
                        else if (diff < 0)
                        begin
                            turn = make_cmd(uoad_pkg::CMD_RIGHT, model_cfg.speed_mid,
                                            model_cfg.speed_slow);
                            has_turn = 1'b1;
                        end
                    end
                    RULE_FRONT_RIGHT:
                    begin
                        // r <= 15 here, so the room check always passes
                        if (r <= 28)
                        begin
                            turn = make_cmd(uoad_pkg::CMD_LEFT, model_cfg.speed_mid,
                                            model_cfg.speed_slow);
                            has_turn = 1'b1;
                        end
                    end
                    RULE_FRONT_LEFT:
                    begin
                        if (l <= 28)
                        begin
                            turn = make_cmd(uoad_pkg::CMD_RIGHT, model_cfg.speed_slow,
                                            model_cfg.speed_mid);
                            has_turn = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (diff > 0)
                        begin
                            turn = make_cmd(uoad_pkg::CMD_LEFT, model_cfg.speed_mid,
                                            model_cfg.speed_slow);
                            has_turn = 1'b1;
                        end
                        else if (diff < 0)
                        begin
                            turn = make_cmd(uoad_pkg::CMD_RIGHT, model_cfg.speed_slow,
                                            model_cfg.speed_mid);
                            has_turn = 1'b1;
                        end
                    end
                endcase
                // turn stamp moves even when sides are equal and no turn goes out
                turn_stamp = t.now_ms;
            end
        end
        action_stamp = t.now_ms;

        if (has_turn)
        begin
            turn.last = 1'b1;
            expected_cmds.push_back(lead);
            expected_cmds.push_back(turn);
        end
        else
        begin
            lead.last = 1'b1;
            expected_cmds.push_back(lead);
        end
    endtask

    // ---------------- pacing ----------------

    // each run is either calm (no idling) or has random gaps, picked at random
    function automatic int pick_gap(inout int run_left, inout bit calm);
        int unsigned roll;
        if (run_left == 0)
        begin
            run_left = $urandom_range(20, 120);
            calm = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_commands(offered);
                send_gap = pick_gap(send_run, send_calm);
                if (flood)
                    send_gap = 0;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_ticks.size() != 0)
                begin
                    offered = pending_ticks.pop_front();
                    in_valid <= 1'b1;
                    now_ms   <= offered.now_ms;
                    front_cm <= offered.front_cm;
                    left_cm  <= offered.left_cm;
                    right_cm <= offered.right_cm;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver ----------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (holds_done != hold_requests)
            begin
                holds_done++;
                recv_stall = LONG_HOLD;
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_stall = pick_gap(recv_run, recv_calm);
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        motor_cmd_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_cmds.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected transfer cmd=%0d first=%0d second=%0d last=%0b",
                             $realtime, command, first_speed, second_speed, last);
            end
            else
            begin
                want = expected_cmds.pop_front();
                if (command !== want.command || first_speed !== want.first_speed ||
                    second_speed !== want.second_speed || last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 $realtime, want.command, want.first_speed, want.second_speed,
                                 want.last, command, first_speed, second_speed, last);
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic add_tick(input logic [31:0] t_ms, input logic [8:0] f,
                            input logic [8:0] l, input logic [8:0] r);
        tick_t t;
        t.now_ms   = t_ms;
        t.front_cm = f;
        t.left_cm  = l;
        t.right_cm = r;
        pending_ticks.push_back(t);
        clock_ms = t_ms;
    endtask

    // distances leaning toward the rule thresholds
    function automatic logic [8:0] pick_cm();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return 9'($urandom_range(0, 30));
        if (roll < 60)
            return 9'($urandom_range(0, 60));
        if (roll < 85)
            return 9'($urandom_range(0, 511));
        case ($urandom_range(0, 9))
            0: return 9'd2;
            1: return 9'd3;
            2: return 9'd15;
            3: return 9'd16;
            4: return 9'd20;
            5: return 9'd21;
            6: return 9'd23;
            7: return 9'd49;
            8: return 9'd50;
            default: return 9'd511;
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return 32'($urandom_range(0, 40));
        if (roll < 65)
            return 32'($urandom_range(40, 400));
        if (roll < 90)
            return 32'($urandom_range(300, 70000));
        return $urandom;
    endfunction

    task automatic add_random(input int count);
        for (int i = 0; i < count; i++)
            add_tick(clock_ms + pick_step(), pick_cm(), pick_cm(), pick_cm());
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            uoad_pkg::REG_SPEED_FAST:      model_cfg.speed_fast         = val[9:0];
            uoad_pkg::REG_SPEED_MID:       model_cfg.speed_mid          = val[9:0];
            uoad_pkg::REG_SPEED_SLOW:      model_cfg.speed_slow         = val[9:0];
            uoad_pkg::REG_BACK_INTERVAL:   model_cfg.back_interval_ms   = val;
            uoad_pkg::REG_ACTION_INTERVAL: model_cfg.action_interval_ms = val;
            uoad_pkg::REG_TURN_INTERVAL:   model_cfg.turn_interval_ms   = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] fast, input logic [15:0] mid,
                                  input logic [15:0] slow, input logic [15:0] back_ms,
                                  input logic [15:0] action_ms, input logic [15:0] turn_ms);
        write_reg(uoad_pkg::REG_SPEED_FAST, fast);
        write_reg(REG_UNUSED_A, 16'($urandom));
        write_reg(uoad_pkg::REG_SPEED_MID, mid);
        write_reg(uoad_pkg::REG_SPEED_SLOW, slow);
        write_reg(uoad_pkg::REG_BACK_INTERVAL, back_ms);
        write_reg(uoad_pkg::REG_ACTION_INTERVAL, action_ms);
        write_reg(REG_UNUSED_B, 16'($urandom));
        write_reg(uoad_pkg::REG_TURN_INTERVAL, turn_ms);
    endtask

    // idle: all ticks taken, all commands seen, pipeline drained
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_ticks.size() != 0 || in_valid || expected_cmds.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        model_cfg.speed_fast         = 10'd80;
        model_cfg.speed_mid          = 10'd70;
        model_cfg.speed_slow         = 10'd50;
        model_cfg.back_interval_ms   = 16'd300;
        model_cfg.action_interval_ms = 16'd100;
        model_cfg.turn_interval_ms   = 16'd300;
        left_filt    = '0;
        right_filt   = '0;
        action_stamp = '0;
        turn_stamp   = '0;
        clock_ms     = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every rule, gates open and closed, wrap of the time count
        add_tick(32'd0,     9'd0,   9'd0,   9'd0);    // stamps at zero: gated
        add_tick(32'd1000,  9'd10,  9'd5,   9'd12);   // all blocked, turn right
        add_tick(32'd1100,  9'd10,  9'd12,  9'd5);    // back gate still closed
        add_tick(32'd2000,  9'd15,  9'd15,  9'd15);   // all blocked, equal sides
        add_tick(32'd2100,  9'd18,  9'd40,  9'd10);   // front+right, turn gate closed
        add_tick(32'd3000,  9'd20,  9'd40,  9'd15);   // front+right, turn left
        add_tick(32'd4000,  9'd20,  9'd15,  9'd40);   // front+left, turn right
        add_tick(32'd5000,  9'd100, 9'd18,  9'd30);   // side close, right
        add_tick(32'd6000,  9'd3,   9'd30,  9'd10);   // front+right, turn left
        add_tick(32'd7000,  9'd2,   9'd30,  9'd30);   // front close, no turn
        add_tick(32'd8000,  9'd23,  9'd30,  9'd25);   // front close, left
        add_tick(32'd9000,  9'd24,  9'd30,  9'd30);   // all clear
        add_tick(32'd9050,  9'd511, 9'd511, 9'd511);  // replaced sides, gated
        add_tick(32'd10000, 9'd511, 9'd511, 9'd511);
        add_tick(32'd11000, 9'd22,  9'd50,  9'd49);
        add_tick(32'd12000, 9'd511, 9'd0,   9'd511);
        add_tick(32'hFFFF_FF00, 9'd10, 9'd10, 9'd5);  // all blocked, left
        add_tick(32'h0000_0010, 9'd10, 9'd5,  9'd10); // wrapped gap below back gate
        add_tick(32'h0000_0100, 9'd50, 9'd49, 9'd0);
        add_tick(32'h8000_0000, 9'd0,  9'd511, 9'd0);
        add_tick(32'hFFFF_FFFF, 9'd1,  9'd0,  9'd511);
        wait_idle();

        // receiver holds off while ticks keep coming, filling the block
        flood = 1'b1;
        hold_requests++;
        add_random(300);
        repeat (250) @(negedge clk);
        flood = 1'b0;
        wait_idle();

        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_random(250);
        wait_idle();

        apply_settings(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        add_random(250);
        wait_idle();

        repeat (2)
        begin
            apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom_range(0, 600)), 16'($urandom_range(0, 300)),
                           16'($urandom_range(0, 600)));
            add_random(300);
            wait_idle();
        end

        if (mismatch_count == 0 && expected_cmds.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/uoad_pkg.sv
hw/rtl/uoad_front.sv
hw/rtl/uoad_queue.sv
hw/rtl/uoad_back.sv
hw/rtl/ultrasonic_obstacle_avoid_decider.sv
test/ultrasonic_obstacle_avoid_decider_test.sv
